>>> sv/multi_waveform_nco_assert.svh
// Assertion macros shared by the oscillator modules.
`ifndef MULTI_WAVEFORM_NCO_ASSERT_SVH
`define MULTI_WAVEFORM_NCO_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define MWNCO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define MWNCO_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mwnco_pkg.sv
// Shared types, constants and the sine table builder for the oscillator.
`default_nettype none

package mwnco_pkg;

	localparam int PHASE_W    = 32;
	localparam int SAMPLE_W   = 16;
	localparam int ROM_ADDR_W = 10;

	localparam int MAG_W     = SAMPLE_W - 1;
	localparam int ROM_N     = 2 ** ROM_ADDR_W;
	localparam int ROM_DEPTH = ROM_N + 1;
	localparam int ROM_IDX_W = ROM_ADDR_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Full scale is all ones in the magnitude bits.
	localparam logic [MAG_W-1:0]           FS_MAG = {MAG_W{1'b1}};
	localparam logic signed [SAMPLE_W-1:0] POS_FS = {1'b0, FS_MAG};
	localparam logic signed [SAMPLE_W-1:0] NEG_FS = -POS_FS;

	// Half a cycle of phase.
	localparam logic [PHASE_W-1:0] HALF_PHASE = {1'b1, {(PHASE_W-1){1'b0}}};

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(1);

	// Constants of the Q31 sine series used to build the table.
	localparam logic [63:0] HALFPI_Q31 = 64'd3373259426;
	localparam logic [63:0] HALF_Q31   = 64'h0000_0000_8000_0000;
	localparam logic [63:0] DIVS [7]   = '{64'd210, 64'd156, 64'd110, 64'd72,
		64'd42, 64'd20, 64'd6};

	typedef enum logic [1:0] {
		MODE_SINE     = 2'd0,
		MODE_SAW      = 2'd1,
		MODE_SQUARE   = 2'd2,
		MODE_TRIANGLE = 2'd3
	} wave_mode_t;

	// Contents of the input register, handed to the waveform stage.
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [PHASE_W-1:0] phase;
	} stage_t;

	typedef logic [MAG_W-1:0] sine_rom_t [ROM_DEPTH];

	// Quarter-wave sine magnitudes, worked out once at elaboration.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] m;
		logic [63:0] s;
		logic [63:0] v;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			x  = (HALFPI_Q31 * 64'(k) + 64'(ROM_N / 2)) >> ROM_ADDR_W;
			x2 = (x * x) >> 31;
			t  = HALF_Q31;
			for (int i = 0; i < 7; i++) begin
				m = ((x2 * t) >> 31) / DIVS[i];
				t = (m >= HALF_Q31) ? 64'd0 : HALF_Q31 - m;
			end
			s = (x * t) >> 31;
			v = (s * 64'(FS_MAG) + (HALF_Q31 >> 1)) >> 31;
			if (v > 64'(FS_MAG)) begin
				v = 64'(FS_MAG);
			end
			rom[k] = v[MAG_W-1:0];
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

>>> sv/multi_waveform_nco.sv
// Top level of the four-waveform numerically controlled oscillator.
//
//   Channel  Direction  Handshake             Word contents
//   cfg      in         cfg_wr_en             cfg_index, cfg_wdata
//   in       in         in_valid / in_ready   block_end
//   out      out        out_valid / out_ready sample_value, last_of_block
//
// One word is accepted every cycle while the output side keeps taking samples.
// A sample is offered once its request has passed the input register, where the
// phase is captured, and then the output register, which also holds the registered
// read of the sine table; a stalled output register holds the request back.
// Reset clears the phase, both configuration registers and the valid flags; the
// sine table is a constant and needs no clearing pass.
// When out_ready is low the output register holds its word and in_ready falls only
// once the input register is also full.
`default_nettype none

module multi_waveform_nco (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [mwnco_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [mwnco_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic                                   block_end,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [mwnco_pkg::SAMPLE_W-1:0]       sample_value,
	output logic                                        last_of_block
);
	import mwnco_pkg::*;

	wave_mode_t         wave_mode_q;
	logic [PHASE_W-1:0] phase_step_q;
	stage_t             stage;
	logic               stage_take;

	// Configuration registers. Writes must arrive only while the oscillator is idle;
	// the block itself does not enforce this. A new mode or step then applies from the
	// next requested sample. An index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q  <= MODE_SINE;
			phase_step_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WAVE_MODE: begin
					wave_mode_q <= wave_mode_t'(cfg_wdata[1:0]);
				end
				REG_PHASE_STEP: begin
					phase_step_q <= cfg_wdata[PHASE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The accumulator hands the current phase to the waveform stage and then
	// adds the step, wrapping naturally over one full cycle.
	mwnco_phase u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_step (phase_step_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.block_end  (block_end),
		.stage_take (stage_take),
		.stage      (stage)
	);

	// The waveform stage turns the phase into a saturated sample and keeps it
	// in the output register until the consumer takes it.
	mwnco_wave u_wave (
		.clk           (clk),
		.arst_n        (arst_n),
		.wave_mode     (wave_mode_q),
		.stage         (stage),
		.stage_take    (stage_take),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample_value  (sample_value),
		.last_of_block (last_of_block)
	);

endmodule

`default_nettype wire

>>> sv/mwnco_phase.sv
// Phase accumulator and input register of the oscillator.
`default_nettype none
`include "multi_waveform_nco_assert.svh"

module mwnco_phase (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [mwnco_pkg::PHASE_W-1:0]   phase_step,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            block_end,
	input  wire logic                            stage_take,
	output mwnco_pkg::stage_t                    stage
);
	import mwnco_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_next;
	logic               valid_s1;
	logic               last_s1;
	logic [PHASE_W-1:0] phase_s1;
	logic               in_fire;

	assign in_ready   = !valid_s1 || stage_take;
	assign in_fire    = in_valid && in_ready;
	assign phase_next = phase_q + phase_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q <= phase_next;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (stage_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// The sample is taken from the phase before this word's step is added.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			phase_s1 <= phase_q;
			last_s1  <= block_end;
		end
	end

	assign stage = '{valid: valid_s1, last: last_s1, phase: phase_s1};

	`MWNCO_ASSERT_NXT(a_phase_steps, in_fire, phase_q == $past(phase_next), "phase did not advance by one step")
	`MWNCO_ASSERT_NXT(a_phase_holds, !in_fire, $stable(phase_q), "phase moved without an accepted word")

endmodule

`default_nettype wire

>>> sv/mwnco_wave.sv
// Waveform generation, sine table and output register of the oscillator.
`default_nettype none
`include "multi_waveform_nco_assert.svh"

module mwnco_wave (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire mwnco_pkg::wave_mode_t                 wave_mode,
	input  wire mwnco_pkg::stage_t                     stage,
	output logic                                       stage_take,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [mwnco_pkg::SAMPLE_W-1:0]      sample_value,
	output logic                                       last_of_block
);
	import mwnco_pkg::*;

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {MAG_W{1'b0}}};
	localparam int PROD_W = PHASE_W + MAG_W;

	logic                        load;
	logic [1:0]                  quad;
	logic [ROM_ADDR_W-1:0]       rom_addr;
	logic [ROM_IDX_W-1:0]        rom_idx;
	logic signed [PHASE_W:0]     saw_num;
	logic [PHASE_W-1:0]          tri_dist;
	logic [PHASE_W+1:0]          tri_wide;
	logic signed [PHASE_W:0]     tri_num;
	logic signed [PHASE_W:0]     ramp_num;
	logic                        ramp_neg;
	logic [PHASE_W-1:0]          ramp_mag;
	logic [PROD_W-1:0]           ramp_prod;
	logic [MAG_W-1:0]            ramp_abs;
	logic signed [SAMPLE_W-1:0]  ramp_val;
	logic signed [SAMPLE_W-1:0]  square_val;
	logic                        valid_s2;
	logic signed [SAMPLE_W-1:0]  sample_s2;
	logic                        last_s2;

	assign stage_take = !valid_s2 || out_ready;
	assign load       = stage.valid && stage_take;

	// Sine: the quadrant mirrors the table address and sets the sign.
	assign quad     = stage.phase[PHASE_W-1 -: 2];
	assign rom_addr = stage.phase[PHASE_W-3 -: ROM_ADDR_W];
	assign rom_idx  = quad[0] ? ROM_IDX_W'(ROM_N) - {1'b0, rom_addr} : {1'b0, rom_addr};

	// Saw and triangle share one scaling by full scale with rounding.
	always_comb begin
		saw_num  = $signed({2'b01, {(PHASE_W-1){1'b0}}}) - $signed({1'b0, stage.phase});
		tri_dist = saw_num[PHASE_W] ? PHASE_W'(-saw_num) : PHASE_W'(saw_num);
		tri_wide = {1'b0, tri_dist, 1'b0} - {3'b001, {(PHASE_W-1){1'b0}}};
		tri_num  = $signed(tri_wide[PHASE_W:0]);
		ramp_num = (wave_mode == MODE_SAW) ? saw_num : tri_num;
		ramp_neg = ramp_num[PHASE_W];
		ramp_mag = ramp_neg ? PHASE_W'(-ramp_num) : PHASE_W'(ramp_num);
		ramp_prod = PROD_W'(ramp_mag) * PROD_W'(FS_MAG) + PROD_W'(HALF_PHASE >> 1);
		ramp_abs = ramp_prod[PHASE_W-1 +: MAG_W];
		ramp_val = ramp_neg ? -$signed({1'b0, ramp_abs}) : $signed({1'b0, ramp_abs});
		square_val = (stage.phase <= HALF_PHASE) ? POS_FS : NEG_FS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (stage_take) begin
			valid_s2 <= stage.valid;
		end
	end

	// The table read is registered here, together with the other waveforms.
	always_ff @(posedge clk) begin
		if (load) begin
			last_s2 <= stage.last;
			case (wave_mode)
				MODE_SINE: begin
					sample_s2 <= quad[1] ? -$signed({1'b0, SINE_ROM[rom_idx]})
						: $signed({1'b0, SINE_ROM[rom_idx]});
				end
				MODE_SQUARE: begin
					sample_s2 <= square_val;
				end
				default: begin
					sample_s2 <= ramp_val;
				end
			endcase
		end
	end

	assign out_valid     = valid_s2;
	assign sample_value  = sample_s2;
	assign last_of_block = last_s2;

	`MWNCO_ASSERT_NOW(a_no_min_code, valid_s2, sample_s2 != SAMPLE_MIN, "sample outside symmetric range")
	`MWNCO_ASSERT_NXT(a_square_full, load && wave_mode == MODE_SQUARE, sample_s2 == POS_FS || sample_s2 == NEG_FS, "square sample not at full scale")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the four-waveform oscillator, with its own sample predictor.
`timescale 1ns / 1ps

module tb_top;
	import mwnco_pkg::*;

	// The index port is two bits wide, so two codes carry no register at all.
	// Writes to them must leave the oscillator untouched.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	localparam longint FULL_SCALE = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint HALF_TURN  = longint'(1) << (PHASE_W - 1);
	localparam longint unsigned Q31_HALF_PI = 64'd3373259426;
	localparam longint unsigned Q31_UNITY   = 64'h0000_0000_8000_0000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last;
	} sample_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic block_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic last_of_block;

	// Our own view of the oscillator: the quarter-wave table, the registers and
	// the phase, which moves on by one step for every word the block accepts.
	logic [MAG_W-1:0] quarter_sine [0:ROM_N];
	wave_mode_t model_mode;
	logic [PHASE_W-1:0] model_step;
	logic [PHASE_W-1:0] model_phase;
	sample_word_t expected_samples [$];

	int send_idle_pct;
	int recv_idle_pct;
	int calm_left;
	int mismatch_count;
	int samples_checked;
	int mode_tally [4];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	multi_waveform_nco dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.block_end     (block_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample_value  (sample_value),
		.last_of_block (last_of_block)
	);

	// Quarter-wave table from the truncating Q31 sine series in Horner form. The
	// divisors (2j)(2j+1) for j from seven down to one give the odd terms up to the
	// fifteenth power of the angle.
	function automatic void build_quarter_table();
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned term;
		longint unsigned part;
		longint unsigned sn;
		longint unsigned mag;
		for (int k = 0; k <= ROM_N; k++) begin
			ang = (Q31_HALF_PI * longint'(k) + longint'(ROM_N / 2)) >> ROM_ADDR_W;
			ang_sq = (ang * ang) >> 31;
			term = Q31_UNITY;
			for (int j = 7; j >= 1; j--) begin
				part = ((ang_sq * term) >> 31) / longint'((2 * j) * (2 * j + 1));
				term = (part >= Q31_UNITY) ? 64'd0 : Q31_UNITY - part;
			end
			sn = (ang * term) >> 31;
			mag = (sn * longint'(FULL_SCALE) + (Q31_UNITY >> 1)) >> 31;
			if (mag > longint'(FULL_SCALE)) begin
				mag = FULL_SCALE;
			end
			quarter_sine[k] = mag[MAG_W-1:0];
		end
	endfunction

	// Full scale times num over half a turn, rounded half away from zero.
	function automatic longint scale_to_full(longint num);
		longint mag;
		longint r;
		mag = (num < 0) ? -num : num;
		r = (mag * FULL_SCALE + (HALF_TURN >>> 1)) >>> (PHASE_W - 1);
		if (r > FULL_SCALE) begin
			r = FULL_SCALE;
		end
		return (num < 0) ? -r : r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] waveform_at(wave_mode_t mode,
			logic [PHASE_W-1:0] ph);
		logic [1:0] quad;
		logic [ROM_ADDR_W-1:0] frac;
		int idx;
		longint offset;
		longint r;
		case (mode)
			MODE_SINE: begin
				// The odd quadrants read the table backwards, the lower half is negated.
				quad = ph[PHASE_W-1 -: 2];
				frac = ph[PHASE_W-3 -: ROM_ADDR_W];
				idx = quad[0] ? ROM_N - int'(frac) : int'(frac);
				r = longint'(quarter_sine[idx]);
				if (quad[1]) begin
					r = -r;
				end
			end
			MODE_SAW: begin
				r = scale_to_full(HALF_TURN - longint'(ph));
			end
			MODE_SQUARE: begin
				// Exactly half a turn still counts as the high half.
				r = (longint'(ph) <= HALF_TURN) ? FULL_SCALE : -FULL_SCALE;
			end
			default: begin
				offset = HALF_TURN - longint'(ph);
				if (offset < 0) begin
					offset = -offset;
				end
				r = scale_to_full(2 * offset - HALF_TURN);
			end
		endcase
		if (r > FULL_SCALE) begin
			r = FULL_SCALE;
		end
		if (r < -FULL_SCALE) begin
			r = -FULL_SCALE;
		end
		return r[SAMPLE_W-1:0];
	endfunction

	// Now and then both sides stop idling for a while, so that runs of back to
	// back words occur even under the heavy idle settings.
	always @(negedge clk) begin
		if (calm_left != 0) begin
			calm_left <= calm_left - 1;
		end else if ($urandom_range(63) == 0) begin
			calm_left <= $urandom_range(40, 8);
		end
		out_ready <= (calm_left != 0) || ($urandom_range(99) >= recv_idle_pct);
	end

	// Every sample the block hands over is compared with the oldest expectation.
	always @(posedge clk) begin
		sample_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word: expected none, got sample %0d last %0b",
					$time, sample_value, last_of_block);
			end else begin
				want = expected_samples.pop_front();
				samples_checked++;
				if (sample_value !== want.value) begin
					mismatch_count++;
					$display("%0t: sample_value mismatch: expected %0d, got %0d",
						$time, want.value, sample_value);
				end
				if (last_of_block !== want.last) begin
					mismatch_count++;
					$display("%0t: last_of_block mismatch: expected %0b, got %0b",
						$time, want.last, last_of_block);
				end
			end
		end
	end

	// Offers one request word and predicts its sample once it has been taken.
	// Entered and left at a falling edge; valid stays high on the way out, so the
	// next call either moves straight on or lowers it for a gap.
	task automatic send_word(input logic last_flag);
		int gap;
		gap = 0;
		if (calm_left == 0) begin
			while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
				gap++;
			end
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			block_end <= $urandom_range(1);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		block_end <= last_flag;
		do begin
			@(posedge clk);
		end while (!in_ready);
		expected_samples.push_back('{waveform_at(model_mode, model_phase), last_flag});
		mode_tally[model_mode]++;
		model_phase = model_phase + model_step;
		@(negedge clk);
	endtask

	// Brings the block to rest: no request offered and every sample delivered.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// One register write; the enable is then held low before the task returns, so that back
	// to back writes never raise and lower the enable at the same edge.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_WAVE_MODE: model_mode = wave_mode_t'(data[1:0]);
			REG_PHASE_STEP: model_step = data[PHASE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wdata <= $urandom;
		@(negedge clk);
	endtask

	// Chooses the step so that, after one word, the phase sits exactly on target.
	task automatic steer_phase(input logic [PHASE_W-1:0] target);
		settle();
		set_reg(REG_PHASE_STEP, target - model_phase);
		send_word(1'b0);
	endtask

	// Straight out of reset: sine, zero step and zero phase give silence.
	task automatic test_reset_defaults();
		send_word(1'b0);
		send_word(1'b1);
		settle();
	endtask

	// A quarter-turn step lands on each quadrant boundary of the sine table,
	// including the end entry reached when the table is read backwards.
	task automatic test_sine_quadrants();
		set_reg(REG_PHASE_STEP, HALF_PHASE >> 1);
		repeat (4) send_word(1'b0);
		settle();
	endtask

	// The square wave is still high at exactly half a turn and low just after it.
	task automatic test_square_threshold();
		set_reg(REG_WAVE_MODE, MODE_SQUARE);
		repeat (4) send_word(1'b0);
		settle();
		set_reg(REG_PHASE_STEP, HALF_PHASE + 1);
		send_word(1'b1);
		send_word(1'b0);
		settle();
	endtask

	// The saw at zero phase, with the largest step walking backwards from the top,
	// and at the zero crossing.
	task automatic test_saw_extremes();
		set_reg(REG_WAVE_MODE, MODE_SAW);
		steer_phase('0);
		settle();
		set_reg(REG_PHASE_STEP, '1);
		repeat (3) send_word(1'b0);
		steer_phase(HALF_PHASE);
		send_word(1'b1);
		settle();
	endtask

	// The triangle peaks at zero phase and bottoms out at half a turn.
	task automatic test_triangle_extremes();
		set_reg(REG_WAVE_MODE, MODE_TRIANGLE);
		steer_phase('0);
		send_word(1'b0);
		steer_phase(HALF_PHASE);
		send_word(1'b1);
		settle();
	endtask

	// Surplus data bits above the mode field are dropped, and the two spare
	// indexes change nothing.
	task automatic test_register_decode();
		set_reg(REG_WAVE_MODE, {{(CFG_DATA_W-2){1'b1}}, MODE_SAW});
		set_reg(REG_PHASE_STEP, $urandom);
		set_reg(REG_SPARE_2, $urandom);
		set_reg(REG_SPARE_3, '1);
		send_word(1'b0);
		send_word(1'b1);
		settle();
	endtask

	// Streams of random length, each with a fresh mode and step. The steps mix the
	// corner values, slow sweeps that visit neighbouring table entries and fully
	// random values.
	task automatic test_random_streams(input int words_wanted);
		int sent;
		int len;
		logic [PHASE_W-1:0] step;
		wave_mode_t mode;
		sent = 0;
		while (sent < words_wanted) begin
			settle();
			mode = wave_mode_t'($urandom_range(3));
			case ($urandom_range(9))
				0: step = '0;
				1: step = 1;
				2: step = '1;
				3: step = HALF_PHASE;
				4: step = HALF_PHASE >> 1;
				5, 6: step = $urandom_range(1 << 24, 1);
				default: step = $urandom;
			endcase
			set_reg(REG_WAVE_MODE, ($urandom & ~32'd3) | CFG_DATA_W'(mode));
			set_reg(REG_PHASE_STEP, step);
			if ($urandom_range(3) == 0) begin
				set_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
			end
			len = $urandom_range(60, 10);
			repeat (len) send_word($urandom_range(7) == 0);
			sent += len;
		end
		settle();
	endtask

	initial begin
		int spare;
		build_quarter_table();
		model_mode = MODE_SINE;
		model_step = '0;
		model_phase = '0;
		mismatch_count = 0;
		samples_checked = 0;
		calm_left = 0;
		mode_tally = '{default: 0};
		send_idle_pct = 29;
		recv_idle_pct = 75;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_sine_quadrants();
		test_square_threshold();
		test_saw_extremes();
		test_triangle_extremes();
		test_register_decode();

		test_random_streams(700);
		send_idle_pct = 75;
		recv_idle_pct = 29;
		test_random_streams(700);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_streams(700);

		// Give stray words a chance to show up after the last expected one.
		spare = 0;
		while (expected_samples.size() != 0 && spare < 2000) begin
			@(negedge clk);
			spare++;
		end
		repeat (8) @(negedge clk);
		if (expected_samples.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d expected samples never arrived", $time,
				expected_samples.size());
		end

		$display("Checked %0d samples: %0d sine, %0d saw, %0d square, %0d triangle.",
			samples_checked, mode_tally[MODE_SINE], mode_tally[MODE_SAW],
			mode_tally[MODE_SQUARE], mode_tally[MODE_TRIANGLE]);
		$display("Idle mixes sender/receiver 29/75, 75/29 and none; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/mwnco_pkg.sv
sv/mwnco_phase.sv
sv/mwnco_wave.sv
sv/multi_waveform_nco.sv
tb/tb_top.sv
